// File: rtl/tsfe_pkg.sv
// Shared types and constants for the triangle strip/fan expander.
// Used by every module of the block; depends on nothing.

package tsfe_pkg;

   // Primitive mode codes as written to the mode register.
   localparam logic [1:0] MODE_LIST  = 2'd0;
   localparam logic [1:0] MODE_STRIP = 2'd1;
   localparam logic [1:0] MODE_FAN   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PRIM_MODE    = 2'd0;
   localparam logic [1:0] CSR_BASE_VERTEX  = 2'd1;
   localparam logic [1:0] CSR_VERTEX_COUNT = 2'd2;

   // Priming phase at which triangles start to come out.
   localparam logic [1:0] PHASE_FULL = 2'd2;

   // One job handed from the classifier to the emitter.
   typedef struct packed {
      logic [31:0] idx0;
      logic [31:0] idx1;
      logic [31:0] idx2;
      logic        triple;   // three results instead of one
      logic        err;      // single error result
   } job_type;

endpackage

// File: rtl/tsfe_front.sv
// Request side: accepts indices, tracks strip/fan state and builds jobs.
// Depends on tsfe_pkg.

module tsfe_front
   import tsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  prim_mode,
   input  logic [31:0] vertex_count,
   input  logic        req_fire,
   input  logic [31:0] req_index,
   input  logic        req_last,
   output logic        push,
   output job_type     push_job
);

   logic [31:0] slot_a_ff, slot_a_in;
   logic [31:0] slot_b_ff, slot_b_in;
   logic [1:0]  phase_ff, phase_in;
   logic        odd_ff, odd_in;
   logic        error_latched_ff, error_latched_in;

   // Classify the request and compute the next primitive state.
   always_comb begin
      slot_a_in        = slot_a_ff;
      slot_b_in        = slot_b_ff;
      phase_in         = phase_ff;
      odd_in           = odd_ff;
      error_latched_in = error_latched_ff;
      push             = 1'b0;
      push_job         = '0;
      if (req_fire) begin
         if (error_latched_ff) begin
            push = 1'b0;
         end else if (req_index >= vertex_count || prim_mode > MODE_FAN) begin
            push             = 1'b1;
            push_job.err     = 1'b1;
            error_latched_in = 1'b1;
         end else if (prim_mode == MODE_LIST) begin
            push          = 1'b1;
            push_job.idx0 = req_index;
         end else if (phase_ff != PHASE_FULL) begin
            if (req_last) begin
               // A strip or fan that ends before its third index has no triangle.
               push         = 1'b1;
               push_job.err = 1'b1;
            end else begin
               if (phase_ff == 2'd0) begin
                  slot_a_in = req_index;
               end else begin
                  slot_b_in = req_index;
               end
               phase_in = phase_ff + 2'd1;
               odd_in   = ~odd_ff;
            end
         end else if (prim_mode == MODE_STRIP) begin
            // Odd positions swap the last two corners to keep the winding.
            push            = 1'b1;
            push_job.triple = 1'b1;
            push_job.idx0   = slot_a_ff;
            push_job.idx1   = odd_ff ? req_index : slot_b_ff;
            push_job.idx2   = odd_ff ? slot_b_ff : req_index;
            slot_a_in       = slot_b_ff;
            slot_b_in       = req_index;
            odd_in          = ~odd_ff;
         end else begin
            push            = 1'b1;
            push_job.triple = 1'b1;
            push_job.idx0   = slot_a_ff;
            push_job.idx1   = slot_b_ff;
            push_job.idx2   = req_index;
            slot_b_in       = req_index;
            odd_in          = ~odd_ff;
         end
         // The last index of a primitive returns everything to its start.
         if (req_last) begin
            slot_a_in        = '0;
            slot_b_in        = '0;
            phase_in         = '0;
            odd_in           = 1'b0;
            error_latched_in = 1'b0;
         end
      end
   end

   // Kept indices carry no reset; they are rewritten before they are used.
   always_ff @(posedge clock) begin
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= '0;
         odd_ff           <= 1'b0;
         error_latched_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         odd_ff           <= odd_in;
         error_latched_ff <= error_latched_in;
      end
   end

   // The phase counter saturates at the full state.
   assert property (@(posedge clock) disable iff (reset) phase_ff <= PHASE_FULL)
      else $error("phase counter ran past its full state");

   // A failed primitive produces nothing more, its last index included.
   assert property (@(posedge clock) disable iff (reset) error_latched_ff |-> !push)
      else $error("job pushed while the primitive is in error");

endmodule

// File: rtl/tsfe_queue.sv
// Short job queue between the request side and the result side.
// Depends on tsfe_pkg.

module tsfe_queue
   import tsfe_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // No write into a full queue and no read from an empty one.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into a full job queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("pop from an empty job queue");

endmodule

// File: rtl/tsfe_back.sv
// Result side: expands each job into single-index results, base added except for errors.
// Depends on tsfe_pkg.

module tsfe_back
   import tsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] base_vertex,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tuser
);

   logic [1:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        user_ff, user_in;
   logic        out_free;
   logic        emit;
   logic        job_done;
   logic [31:0] pick;

   assign out_free = !valid_ff || rsp_tready;
   assign emit     = out_free && head_valid;
   assign job_done = head_job.triple ? (cnt_ff == 2'd2) : 1'b1;
   assign pop      = emit && job_done;

   // Pick the corner for the current result slot.
   always_comb begin
      case (cnt_ff)
         2'd0:    pick = head_job.idx0;
         2'd1:    pick = head_job.idx1;
         default: pick = head_job.idx2;
      endcase
   end

   // Load the output register whenever it is free and a job is waiting.
   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (out_free) begin
         valid_in = head_valid;
      end
      if (emit) begin
         data_in = head_job.err ? '0 : base_vertex + pick;
         last_in = job_done;
         user_in = head_job.err;
         cnt_in  = job_done ? 2'd0 : cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

   // An error result is always the sole, final result with a zero index.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && user_ff |-> last_ff && data_ff == '0)
      else $error("malformed error result");

   // The slot counter only moves past zero inside a three-result job.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> head_valid && head_job.triple && cnt_ff != 2'd3)
      else $error("result slot counter out of step with its job");

endmodule

// File: rtl/triangle_strip_fan_expander.sv
// Triangle strip/fan expander: jobs go via the job queue to the output register.
// Results leave at one per cycle while the result side is ready and a job waits;
// a list index gives one result, a strip or fan triangle three, all from the single
// output register fed by the job queue. Priming and ignored indices give no result.
// Synchronous active-high reset clears config, primitive state, queue and output.
// Depends on tsfe_pkg, tsfe_front, tsfe_queue and tsfe_back.

module triangle_strip_fan_expander
   import tsfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] index_value
   input  logic        req_tlast,   // last_index
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] vertex_index
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // [0] range_error
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [1:0]  prim_mode_ff;
   logic [31:0] base_vertex_ff;
   logic [31:0] vertex_count_ff;
   logic        req_fire;
   logic        push;
   logic        pop;
   logic        q_full;
   logic        head_valid;
   job_type     push_job;
   job_type     head_job;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prim_mode_ff    <= MODE_LIST;
         base_vertex_ff  <= '0;
         vertex_count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRIM_MODE:    prim_mode_ff    <= csr_wdata[1:0];
            CSR_BASE_VERTEX:  base_vertex_ff  <= csr_wdata;
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata;
            default:          prim_mode_ff    <= prim_mode_ff;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && req_tready;

   tsfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .prim_mode    (prim_mode_ff),
      .vertex_count (vertex_count_ff),
      .req_fire     (req_fire),
      .req_index    (req_tdata),
      .req_last     (req_tlast),
      .push         (push),
      .push_job     (push_job)
   );

   tsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tsfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .base_vertex (base_vertex_ff),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// File: verif/tsfe_checker.sv
// Checker for the triangle strip/fan expander: watches the request, result and
// register ports, predicts the index stream and compares it result by result.
// Depends on tsfe_pkg for the mode codes, register indexes and priming phase.

module tsfe_checker
   import tsfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [31:0] vertex;
      logic        run_last;
      logic        range_error;
   } vertex_out_type;

   // Shadow copy of the register file.
   logic [1:0]  mode_cfg;
   logic [31:0] base_cfg;
   logic [31:0] count_cfg;

   // Shadow copy of the primitive state.
   logic [31:0] anchor_idx;    // strip: older kept index; fan: first index
   logic [31:0] recent_idx;    // newest kept index
   logic [1:0]  primed;        // indices taken so far, saturating at two
   logic        odd_turn;
   logic        prim_failed;

   vertex_out_type expected_vertices[$];
   int             fail_total;

   task automatic push_vertex(input logic [31:0] v, input logic run_last,
                              input logic range_error);
      vertex_out_type item;
      item.vertex      = v;
      item.run_last    = run_last;
      item.range_error = range_error;
      expected_vertices.insert(expected_vertices.size(), item);
   endtask

   task automatic clear_primitive();
      anchor_idx  = '0;
      recent_idx  = '0;
      primed      = '0;
      odd_turn    = 1'b0;
      prim_failed = 1'b0;
   endtask

   // Expands one accepted index into the triangle-list indices it causes.
   task automatic expand_index(input logic [31:0] idx, input logic last);
      logic [31:0] second;
      logic [31:0] third;
      if (prim_failed) begin
         // The rest of a failed primitive is dropped.
      end else if (idx >= count_cfg || mode_cfg > MODE_FAN) begin
         push_vertex('0, 1'b1, 1'b1);
         prim_failed = 1'b1;
      end else if (mode_cfg == MODE_LIST) begin
         push_vertex(base_cfg + idx, 1'b1, 1'b0);
      end else if (primed < PHASE_FULL) begin
         // A primitive that ends before its first triangle is an error.
         if (last) begin
            push_vertex('0, 1'b1, 1'b1);
         end else begin
            if (primed == 2'd0)
               anchor_idx = idx;
            else
               recent_idx = idx;
            primed   = primed + 2'd1;
            odd_turn = ~odd_turn;
         end
      end else if (mode_cfg == MODE_STRIP) begin
         // Odd positions swap the winding.
         second = odd_turn ? idx : recent_idx;
         third  = odd_turn ? recent_idx : idx;
         push_vertex(base_cfg + anchor_idx, 1'b0, 1'b0);
         push_vertex(base_cfg + second, 1'b0, 1'b0);
         push_vertex(base_cfg + third, 1'b1, 1'b0);
         anchor_idx = recent_idx;
         recent_idx = idx;
         odd_turn   = ~odd_turn;
      end else begin
         push_vertex(base_cfg + anchor_idx, 1'b0, 1'b0);
         push_vertex(base_cfg + recent_idx, 1'b0, 1'b0);
         push_vertex(base_cfg + idx, 1'b1, 1'b0);
         recent_idx = idx;
         odd_turn   = ~odd_turn;
      end
      if (last)
         clear_primitive();
   endtask

   // Compares one accepted result with the oldest expectation.
   task automatic check_vertex();
      vertex_out_type exp_v;
      if (expected_vertices.size() == 0) begin
         $error("unexpected result: vertex_index %h run_last %b range_error %b",
                rsp_tdata, rsp_tlast, rsp_tuser);
         fail_total++;
      end else begin
         exp_v = expected_vertices.pop_front();
         if (rsp_tdata !== exp_v.vertex) begin
            $error("vertex_index: expected %h, got %h", exp_v.vertex, rsp_tdata);
            fail_total++;
         end
         if (rsp_tlast !== exp_v.run_last) begin
            $error("run_last: expected %b, got %b", exp_v.run_last, rsp_tlast);
            fail_total++;
         end
         if (rsp_tuser !== exp_v.range_error) begin
            $error("range_error: expected %b, got %b", exp_v.range_error, rsp_tuser);
            fail_total++;
         end
      end
   endtask

   // Everything is sampled at the rising edge, on the values settled before it.
   always @(posedge clock) begin
      if (reset) begin
         mode_cfg  = MODE_LIST;
         base_cfg  = '0;
         count_cfg = '0;
         clear_primitive();
         expected_vertices.delete();
         fail_total = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRIM_MODE:    mode_cfg  = csr_wdata[1:0];
               CSR_BASE_VERTEX:  base_cfg  = csr_wdata;
               CSR_VERTEX_COUNT: count_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expand_index(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_vertex();
      end
      mismatches  <= fail_total;
      outstanding <= expected_vertices.size();
   end

endmodule

// File: verif/tb_triangle_strip_fan_expander.sv
// Testbench top for the triangle strip/fan expander: drives index requests and
// register writes, stalls the result side, and reports the verdict.
// Depends on tsfe_pkg, triangle_strip_fan_expander and tsfe_checker.

module tb_triangle_strip_fan_expander;
   import tsfe_pkg::*;

   // Mode code outside the defined set; the block must reject every index.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] index_value
   logic        req_tlast;    // last_index
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] vertex_index
   logic        rsp_tlast;    // run_last
   logic        rsp_tuser;    // [0] range_error
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        steady = 1'b0;  // no idling on either side while set
   int          mismatches;
   int          outstanding;

   triangle_strip_fan_expander u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tsfe_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   // The result side stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 13);
   end

   // Writes all three registers on consecutive edges.
   task automatic configure(input logic [1:0] mode, input logic [31:0] base,
                            input logic [31:0] count);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PRIM_MODE;
      csr_wdata <= {30'd0, mode};
      @(posedge clock);
      csr_index <= CSR_BASE_VERTEX;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_VERTEX_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offers one index request and returns at the edge that accepts it.
   task automatic send_index(input logic [31:0] idx, input logic last);
      if (!steady && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= idx;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drains all expected results, then lets priming requests settle too.
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Mostly in range, sometimes at or past vertex_count, now and then anything.
   function automatic logic [31:0] pick_index(input logic [31:0] count);
      int roll;
      roll = $urandom_range(19);
      if (roll == 0)
         return $urandom;
      else if (roll < 3 || count == 0)
         return (count == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                         : $urandom_range(32'hFFFF_FFFF, count);
      else
         return $urandom_range(count - 1, 0);
   endfunction

   initial begin
      int          sent;
      int          prims;
      int          len;
      int          roll;
      logic        open_end;
      logic [1:0]  mode;
      logic [31:0] base;
      logic [31:0] count;

      sent = 0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_PRIM_MODE;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: vertex_count is zero, so any index is out of range.
      send_index(32'd0, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // List mode with wrapping base; an error drops the rest of the primitive.
      configure(MODE_LIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_index(32'd0, 1'b0);
      send_index(32'hFFFF_FFFE, 1'b0);
      send_index(32'hFFFF_FFFF, 1'b0);
      send_index(32'd3, 1'b0);
      send_index(32'd4, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // Strip mode: full strip, short strips, error in the middle.
      configure(MODE_STRIP, 32'd5, 32'd16);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b0);
      send_index(32'd4, 1'b1);
      send_index(32'd7, 1'b1);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b1);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd20, 1'b0);
      send_index(32'd3, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // Fan mode, then a primitive left open across a mode change.
      configure(MODE_FAN, 32'd0, 32'd16);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b1);
      send_index(32'd9, 1'b0);
      send_index(32'd8, 1'b0);
      send_index(32'd7, 1'b0);
      wait_idle(SETTLE_CYCLES);
      configure(MODE_STRIP, 32'd0, 32'd16);
      send_index(32'd6, 1'b0);
      send_index(32'd5, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // The undefined mode code rejects every index.
      configure(MODE_UNUSED, 32'd0, 32'd16);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b1);
      wait_idle(SETTLE_CYCLES);

      // Random phases of well-formed primitives with some broken ones mixed in.
      while (sent < 215) begin
         roll = $urandom_range(19);
         if (roll < 3)
            mode = MODE_LIST;
         else if (roll < 11)
            mode = MODE_STRIP;
         else if (roll < 19)
            mode = MODE_FAN;
         else
            mode = MODE_UNUSED;
         case ($urandom_range(3))
            0:       base = 32'd0;
            1:       base = 32'hFFFF_FFFF;
            default: base = $urandom;
         endcase
         case ($urandom_range(9))
            0:       count = 32'd0;
            1:       count = 32'hFFFF_FFFF;
            2, 3:    count = $urandom;
            default: count = $urandom_range(16, 1);
         endcase
         configure(mode, base, count);
         prims = $urandom_range(6, 2);
         for (int p = 0; p < prims; p++) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
            open_end = (p == prims - 1) && ($urandom_range(5) == 0);
            for (int k = 0; k < len; k++) begin
               send_index(pick_index(count), (k == len - 1) && !open_end);
               sent++;
               steady <= (sent >= 100) && (sent < 170);
            end
         end
         wait_idle(SETTLE_CYCLES);
      end

      wait_idle(2 * SETTLE_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
